[hw/rtl/cds_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg
// Types, constants and register codes shared by the charge dock sequencer.
// ----------------------------------------------------------------------------
package cds_pkg;

	localparam int MAX_ROBOTS   = 16;
	localparam int IDX_W        = 4;
	localparam int CNT_W        = $clog2(MAX_ROBOTS + 1);
	localparam int TAKEOUT_DIST = 100;
	localparam int SQ_W         = 34;
	localparam int DIST_W       = SQ_W + 1;
	localparam logic [DIST_W-1:0] TAKEOUT_SQ = DIST_W'(TAKEOUT_DIST * TAKEOUT_DIST);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DOCK_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOCK_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_APPROACH_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_APPROACH_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DOCK_HEADING = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED  = 3'd7;

	localparam logic [15:0] FULL_LEVEL_RST  = 16'd4200;
	localparam logic [15:0] LOW_LEVEL_RST   = 16'd3300;
	localparam logic [7:0]  DRIVE_SPEED_RST = 8'd100;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_DRIVEWAY = 3'd1;
	localparam logic [2:0] PH_INTO     = 3'd2;
	localparam logic [2:0] PH_CHARGE   = 3'd3;
	localparam logic [2:0] PH_OUT      = 3'd4;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [IDX_W-1:0]   robot_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        battery_mv;
		logic               in_motion;
		logic               robot_present;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   target_robot;
		logic signed [15:0] dest_x;
		logic signed [15:0] dest_y;
		logic [7:0]         speed_out;
		logic [8:0]         end_heading;
		logic [2:0]         dock_phase;
		logic               released;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        battery;
		logic               moving;
		logic               present;
	} robot_entry_t;

	localparam int ENTRY_W = $bits(robot_entry_t);

	typedef struct packed {
		logic signed [15:0] dock_x;
		logic signed [15:0] dock_y;
		logic signed [15:0] approach_x;
		logic signed [15:0] approach_y;
		logic [8:0]         dock_heading;
		logic [15:0]        full_level;
		logic [15:0]        low_level;
		logic [7:0]         drive_speed;
	} cfg_t;

	typedef struct packed {
		logic             we;
		logic             re;
		logic [IDX_W-1:0] addr;
		robot_entry_t     wdata;
	} tbl_req_t;

endpackage
`default_nettype wire

[hw/rtl/cds_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cds_if
// Valid/ready channels carrying input beats and result beats.
// ----------------------------------------------------------------------------
interface cds_in_if
	import cds_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface cds_out_if
	import cds_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/charge_dock_sequencer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// charge_dock_sequencer_unit
// Single charge-station docking controller over a 16-entry robot table.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries command beats: a status update (cmd 0) writes one robot
//   table entry and returns nothing; a tick (cmd 1) runs the station.
//   out_ch carries at most one result beat per tick: the station's command
//   to its robot, its phase after the tick and a release flag.
//   cfg_we/cfg_index/cfg_data write the station registers; write them only
//   while no beat is in flight.
//   After an update in_ch stays ready, so updates run back to
//   back. A tick walks the robot table through the RAM's single read port,
//   one entry a cycle, then reads the station robot once more and squares
//   its dock offset: in_ch is ready again in the same cycle that the result
//   becomes valid. A tick with no result frees in_ch once the scan and the
//   selection step are done.
//   A result waits in the output register while out_ch is stalled; the next
//   beat is still accepted, and a tick whose result finds the register full
//   holds until it drains.
//   Reset empties the table (entries read as zero until written), clears all
//   marks and frees the station; no clearing pass is needed.
// ----------------------------------------------------------------------------
module charge_dock_sequencer_unit
	import cds_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	cds_in_if.sink                     in_ch,
	cds_out_if.source                  out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t         cfg_q;
	tbl_req_t     tbl_req;
	robot_entry_t rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dock_x       <= '0;
			cfg_q.dock_y       <= '0;
			cfg_q.approach_x   <= '0;
			cfg_q.approach_y   <= '0;
			cfg_q.dock_heading <= '0;
			cfg_q.full_level   <= FULL_LEVEL_RST;
			cfg_q.low_level    <= LOW_LEVEL_RST;
			cfg_q.drive_speed  <= DRIVE_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DOCK_X:       cfg_q.dock_x       <= cfg_data;
				REG_DOCK_Y:       cfg_q.dock_y       <= cfg_data;
				REG_APPROACH_X:   cfg_q.approach_x   <= cfg_data;
				REG_APPROACH_Y:   cfg_q.approach_y   <= cfg_data;
				REG_DOCK_HEADING: cfg_q.dock_heading <= cfg_data[8:0];
				REG_FULL_LEVEL:   cfg_q.full_level   <= cfg_data;
				REG_LOW_LEVEL:    cfg_q.low_level    <= cfg_data;
				REG_DRIVE_SPEED:  cfg_q.drive_speed  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	cds_robot_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_entry(rd_entry)
	);

	cds_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.tbl_req (tbl_req),
		.rd_entry(rd_entry)
	);
endmodule
`default_nettype wire

[hw/rtl/cds_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cds_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule
`default_nettype wire

[hw/rtl/cds_robot_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cds_robot_table
// Robot table in RAM; entries never written read back as zero.
// ----------------------------------------------------------------------------
module cds_robot_table
	import cds_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire tbl_req_t     req,
	output robot_entry_t      rd_entry
);
	logic [MAX_ROBOTS-1:0] written_q;
	logic                  rd_written_s1;
	logic [ENTRY_W-1:0]    ram_rdata;

	cds_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ROBOTS)
	) u_ram (
		.clk  (clk),
		.we   (req.we),
		.re   (req.re),
		.addr (req.addr),
		.wdata(req.wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q     <= '0;
			rd_written_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				written_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				rd_written_s1 <= written_q[req.addr];
			end
		end
	end

	assign rd_entry = rd_written_s1 ? robot_entry_t'(ram_rdata) : '0;
endmodule
`default_nettype wire

[hw/rtl/cds_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cds_seq
// Tick sequencer: table scan, station selection and phase cascade.
// ----------------------------------------------------------------------------
module cds_seq
	import cds_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	cds_in_if.sink            in_ch,
	cds_out_if.source         out_ch,
	output tbl_req_t          tbl_req,
	input  wire robot_entry_t rd_entry
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SEL   = 3'd2;
	localparam logic [2:0] ST_FETCH = 3'd3;
	localparam logic [2:0] ST_SQ    = 3'd4;
	localparam logic [2:0] ST_EVAL  = 3'd5;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      scan_cnt_q;
	logic                  proc_vld_s1;
	logic [IDX_W-1:0]      proc_idx_s1;
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [15:0]           best_batt_q;
	logic [MAX_ROBOTS-1:0] needs_charge_q;
	logic                  busy_q;
	logic [IDX_W-1:0]      robot_q;
	logic [2:0]            phase_q;
	logic [SQ_W-1:0]       sqx_s2;
	logic [SQ_W-1:0]       sqy_s2;
	logic                  out_valid_q;
	out_item_t             out_item_q;

	logic                  in_acc;
	logic                  scan_issue;
	logic                  mark_new;
	logic                  cand;
	logic signed [16:0]    ex;
	logic signed [16:0]    ey;
	logic [15:0]           ax;
	logic [15:0]           ay;
	logic [31:0]           ax_sq;
	logic [31:0]           ay_sq;
	logic                  far;
	logic [2:0]            ph;
	logic signed [15:0]    dx;
	logic signed [15:0]    dy;
	logic                  rel;
	logic                  load_out;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign scan_issue  = (scan_cnt_q < CNT_W'(MAX_ROBOTS));

	always_comb begin
		tbl_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_ch.payload.cmd == CMD_UPDATE &&
				    ({1'b0, in_ch.payload.robot_index} < (IDX_W+1)'(MAX_ROBOTS))) begin
					tbl_req.we            = 1'b1;
					tbl_req.addr          = in_ch.payload.robot_index;
					tbl_req.wdata.pos_x   = in_ch.payload.pos_x;
					tbl_req.wdata.pos_y   = in_ch.payload.pos_y;
					tbl_req.wdata.battery = in_ch.payload.battery_mv;
					tbl_req.wdata.moving  = in_ch.payload.in_motion;
					tbl_req.wdata.present = in_ch.payload.robot_present;
				end
			end
			ST_SCAN: begin
				tbl_req.re   = scan_issue;
				tbl_req.addr = scan_cnt_q[IDX_W-1:0];
			end
			ST_FETCH: begin
				tbl_req.re   = 1'b1;
				tbl_req.addr = robot_q;
			end
			default: begin
			end
		endcase
	end

	// Mark low robots; the best candidate is chosen from the marks after this tick's update
	assign mark_new = needs_charge_q[proc_idx_s1] |
	                  (rd_entry.present && (rd_entry.battery < cfg.low_level));
	assign cand     = rd_entry.present && mark_new &&
	                  (!found_q || (rd_entry.battery < best_batt_q));

	assign ex  = {rd_entry.pos_x[15], rd_entry.pos_x} - {cfg.dock_x[15], cfg.dock_x};
	assign ey  = {rd_entry.pos_y[15], rd_entry.pos_y} - {cfg.dock_y[15], cfg.dock_y};
	// Offsets stay within 65535 in magnitude, so square the magnitudes
	assign ax    = ex[16] ? 16'(-ex) : ex[15:0];
	assign ay    = ey[16] ? 16'(-ey) : ey[15:0];
	assign ax_sq = {16'd0, ax} * {16'd0, ax};
	assign ay_sq = {16'd0, ay} * {16'd0, ay};
	assign far = ({1'b0, sqx_s2} + {1'b0, sqy_s2}) > TAKEOUT_SQ;

	// Phase cascade: a stopped robot may advance through several phases in one tick
	always_comb begin
		ph  = phase_q;
		dx  = cfg.dock_x;
		dy  = cfg.dock_y;
		rel = 1'b0;
		if (ph == PH_IDLE) begin
			ph = PH_DRIVEWAY;
		end
		if (ph == PH_DRIVEWAY) begin
			dx = cfg.approach_x;
			dy = cfg.approach_y;
			if (!rd_entry.moving) begin
				ph = PH_INTO;
			end
		end
		if (ph == PH_INTO) begin
			dx = cfg.dock_x;
			dy = cfg.dock_y;
			if (!rd_entry.moving) begin
				ph = PH_CHARGE;
			end
		end
		if (ph == PH_CHARGE) begin
			if (rd_entry.battery >= cfg.full_level) begin
				ph = PH_OUT;
			end
			if (far) begin
				ph = PH_DRIVEWAY;
			end
		end
		if (ph == PH_OUT) begin
			dx = cfg.approach_x;
			dy = cfg.approach_y;
			if (!rd_entry.moving) begin
				ph  = PH_IDLE;
				rel = 1'b1;
			end
		end
	end

	assign load_out = (state_q == ST_EVAL) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			scan_cnt_q     <= '0;
			proc_vld_s1    <= 1'b0;
			proc_idx_s1    <= '0;
			found_q        <= 1'b0;
			best_idx_q     <= '0;
			best_batt_q    <= '0;
			needs_charge_q <= '0;
			busy_q         <= 1'b0;
			robot_q        <= '0;
			phase_q        <= PH_IDLE;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_ch.ready && out_valid_q && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_ch.payload.cmd == CMD_TICK) begin
						scan_cnt_q  <= '0;
						proc_vld_s1 <= 1'b0;
						found_q     <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					proc_vld_s1 <= scan_issue;
					proc_idx_s1 <= scan_cnt_q[IDX_W-1:0];
					if (scan_issue) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end else begin
						state_q <= ST_SEL;
					end
					if (proc_vld_s1) begin
						needs_charge_q[proc_idx_s1] <= mark_new;
						if (cand) begin
							found_q     <= 1'b1;
							best_idx_q  <= proc_idx_s1;
							best_batt_q <= rd_entry.battery;
						end
					end
				end
				ST_SEL: begin
					if (busy_q) begin
						state_q <= ST_FETCH;
					end else if (found_q) begin
						busy_q  <= 1'b1;
						robot_q <= best_idx_q;
						phase_q <= PH_IDLE;
						state_q <= ST_FETCH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FETCH: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					// Hold until the output register is free
					if (load_out) begin
						out_valid_q <= 1'b1;
						phase_q     <= ph;
						if (rel) begin
							busy_q                  <= 1'b0;
							robot_q                 <= '0;
							needs_charge_q[robot_q] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SQ) begin
			sqx_s2 <= SQ_W'(ax_sq);
			sqy_s2 <= SQ_W'(ay_sq);
		end
		if (load_out) begin
			out_item_q.target_robot <= robot_q;
			out_item_q.dest_x       <= dx;
			out_item_q.dest_y       <= dy;
			out_item_q.speed_out    <= cfg.drive_speed;
			out_item_q.end_heading  <= cfg.dock_heading;
			out_item_q.dock_phase   <= ph;
			out_item_q.released     <= rel;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_item_q;
endmodule
`default_nettype wire
